/* rtl/cdph_pkg.sv */
// Shared types and constants for the charge-division position histogrammer.
// Used by every module under rtl/ except cdph_ram.
`timescale 1ns / 1ps
`default_nettype none
package cdph_pkg;
  localparam int DEF_NUM_DETECTORS = 24;
  localparam int DEF_NUM_BINS      = 240;
  localparam int DEF_COUNT_WIDTH   = 32;

  localparam int COEF_SEL_W    = 3;
  localparam int COEFS_PER_DET = 5;

  localparam logic [31:0] THRESH_RESET = 32'd384;

  localparam int DIV_NUM_W = 64;
  localparam int DIV_DEN_W = 49;

  localparam logic signed [47:0] END_LIMIT = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [15:0] ONE_Q14   = 16'sd16384;
  // ceil(2^17 / 3), exact divide by 3 for small operands
  localparam logic [16:0] RECIP3 = 17'd43691;

  typedef logic [1:0] opcode_t;
  localparam opcode_t OP_HIT   = 2'd0;
  localparam opcode_t OP_LOAD  = 2'd1;
  localparam opcode_t OP_READ  = 2'd2;
  localparam opcode_t OP_CLEAR = 2'd3;

  typedef logic [2:0] status_t;
  localparam status_t ST_FILLED  = 3'd0;
  localparam status_t ST_NO_EN   = 3'd1;
  localparam status_t ST_BELOW   = 3'd2;
  localparam status_t ST_NO_POS  = 3'd3;
  localparam status_t ST_STORED  = 3'd4;
  localparam status_t ST_READ    = 3'd5;
  localparam status_t ST_CLEARED = 3'd6;

  localparam logic [2:0] CSEL_EGAIN = 3'd0;
  localparam logic [2:0] CSEL_EOFF  = 3'd1;
  localparam logic [2:0] CSEL_GAIN  = 3'd2;
  localparam logic [2:0] CSEL_OFF   = 3'd3;
  localparam logic [2:0] CSEL_BAL   = 3'd4;

  typedef struct packed {
    opcode_t     opcode;
    logic [4:0]  detector;
    logic [2:0]  coef_select;
    logic [31:0] coef_value;
    logic [15:0] energy_raw;
    logic [15:0] far_raw;
    logic [15:0] near_raw;
    logic [7:0]  bin_index;
    logic        det_ok;
    logic        sel_ok;
    logic        bin_ok;
  } cmd_t;
endpackage
`default_nettype wire

/* rtl/charge_division_position_histogram_core.sv */
// Top level of the charge-division position histogrammer: config register,
// front end and back end. Uses cdph_pkg, cdph_front, cdph_back.
//
// Usage:
//   s_axis carries requests: tuser is the opcode (hit, load coefficient,
//   read bin, clear histogram), tdata the operands. m_axis returns one
//   result per request: tuser is the status, tdata the result fields.
//   cfg_wr_en/cfg_wr_data write the energy threshold; write it only idle.
// Throughput:
//   A hit makes at most two passes through the one-bit-per-cycle 64-bit
//   divider (energy, then position). A clear writes one histogram word per
//   cycle. Requests are handled one at a time; a two-entry queue in front
//   takes new requests while one is in work.
// Reset:
//   rst is synchronous. After reset the histogram RAM is zeroed one word
//   per cycle, all 2^(clog2(NUM_DETECTORS)+clog2(NUM_BINS+2)) words (8192 at
//   the defaults), with s_axis_tready low. Coefficients are undefined until
//   loaded. The threshold resets to 1.5.
// Stall:
//   A result waits in the output register while m_axis_tready is low; the
//   back end stops before issuing the next result, then the queue fills and
//   s_axis_tready drops.
`timescale 1ns / 1ps
`default_nettype none
module charge_division_position_histogram_core #(
  parameter int NUM_DETECTORS = cdph_pkg::DEF_NUM_DETECTORS,
  parameter int NUM_BINS      = cdph_pkg::DEF_NUM_BINS,
  parameter int COUNT_WIDTH   = cdph_pkg::DEF_COUNT_WIDTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // detector[4:0], coef_select[7:5], coef_value[39:8], energy_raw[55:40],
  // far_raw[71:56], near_raw[87:72], bin_index[95:88]
  input  logic [95:0] s_axis_tdata,
  // opcode[1:0]
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // position[15:0], bin_number[23:16], bin_count[55:24],
  // calibrated_energy[87:56]
  output logic [87:0] m_axis_tdata,
  // status[2:0]
  output logic [2:0]  m_axis_tuser,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data
);
  logic [31:0]    energy_threshold;
  logic           cmd_valid, cmd_pop, init_busy;
  cdph_pkg::cmd_t cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      energy_threshold <= cdph_pkg::THRESH_RESET;
    end else if (cfg_wr_en) begin
      energy_threshold <= cfg_wr_data;
    end
  end

  cdph_front #(.NUM_DETECTORS(NUM_DETECTORS), .NUM_BINS(NUM_BINS)) u_front (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .hold(init_busy), .cmd_valid(cmd_valid), .cmd(cmd), .cmd_pop(cmd_pop)
  );

  cdph_back #(
    .NUM_DETECTORS(NUM_DETECTORS), .NUM_BINS(NUM_BINS), .COUNT_WIDTH(COUNT_WIDTH)
  ) u_back (
    .clk(clk), .rst(rst), .energy_threshold(energy_threshold),
    .cmd_valid(cmd_valid), .cmd(cmd), .cmd_pop(cmd_pop), .init_busy(init_busy),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
  );

  // no request enters while the histogram is being zeroed
  a_init_blocks: assert property (@(posedge clk) disable iff (rst)
    init_busy |-> !s_axis_tready)
    else $error("request accepted during histogram clear");

  // a filled bin never reports a zero count
  a_fill_count: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser == cdph_pkg::ST_FILLED) |-> m_axis_tdata[55:24] != 32'd0)
    else $error("fill result with zero count");

  // position is only reported with a fill
  a_pos_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser != cdph_pkg::ST_FILLED) |-> m_axis_tdata[15:0] == 16'd0)
    else $error("position reported without fill");
endmodule
`default_nettype wire

/* rtl/cdph_ram.sv */
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module cdph_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

/* rtl/cdph_div.sv */
// Restoring unsigned divider, one quotient bit per cycle.
// Widths from cdph_pkg.
`timescale 1ns / 1ps
`default_nettype none
module cdph_div (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [cdph_pkg::DIV_NUM_W-1:0] num,
  input  logic [cdph_pkg::DIV_DEN_W-1:0] den,
  output logic                           done,
  output logic [cdph_pkg::DIV_NUM_W-1:0] quot
);
  localparam int NW = cdph_pkg::DIV_NUM_W;
  localparam int DW = cdph_pkg::DIV_DEN_W;
  localparam int CW = $clog2(NW + 1);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [DW:0]   rem;
  logic [DW-1:0] den_r;
  logic [NW-1:0] numq;
  logic [DW:0]   trial;
  logic          fits;

  assign trial = {rem[DW-1:0], numq[NW-1]};
  assign fits  = trial >= {1'b0, den_r};
  assign quot  = numq;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem   <= '0;
        numq  <= num;
        den_r <= den;
        cnt   <= CW'(NW);
        busy  <= 1'b1;
      end else if (busy) begin
        rem  <= fits ? (trial - {1'b0, den_r}) : trial;
        numq <= {numq[NW-2:0], fits};
        cnt  <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

/* rtl/cdph_front.sv */
// Front end: takes input requests, range-checks them and queues them.
// Uses cdph_pkg.
`timescale 1ns / 1ps
`default_nettype none
module cdph_front #(
  parameter int NUM_DETECTORS = cdph_pkg::DEF_NUM_DETECTORS,
  parameter int NUM_BINS      = cdph_pkg::DEF_NUM_BINS
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           s_axis_tvalid,
  output logic           s_axis_tready,
  input  logic [95:0]    s_axis_tdata,
  input  logic [1:0]     s_axis_tuser,
  input  logic           hold,
  output logic           cmd_valid,
  output cdph_pkg::cmd_t cmd,
  input  logic           cmd_pop
);
  cdph_pkg::cmd_t in_cmd;
  cdph_pkg::cmd_t q [2];
  logic           wp, rp;
  logic [1:0]     cnt;
  logic           acc;

  always_comb begin
    in_cmd.opcode      = s_axis_tuser;
    in_cmd.detector    = s_axis_tdata[4:0];
    in_cmd.coef_select = s_axis_tdata[7:5];
    in_cmd.coef_value  = s_axis_tdata[39:8];
    in_cmd.energy_raw  = s_axis_tdata[55:40];
    in_cmd.far_raw     = s_axis_tdata[71:56];
    in_cmd.near_raw    = s_axis_tdata[87:72];
    in_cmd.bin_index   = s_axis_tdata[95:88];
    in_cmd.det_ok      = 32'(s_axis_tdata[4:0]) < NUM_DETECTORS;
    in_cmd.sel_ok      = 32'(s_axis_tdata[7:5]) < cdph_pkg::COEFS_PER_DET;
    in_cmd.bin_ok      = 32'(s_axis_tdata[95:88]) < NUM_BINS + 2;
  end

  assign s_axis_tready = !hold && (cnt != 2'd2);
  assign acc           = s_axis_tvalid && s_axis_tready;
  assign cmd_valid     = cnt != 2'd0;
  assign cmd           = q[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (acc) begin
        q[wp] <= in_cmd;
        wp    <= ~wp;
      end
      if (cmd_pop) begin
        rp <= ~rp;
      end
      cnt <= cnt + 2'(acc) - 2'(cmd_pop);
    end
  end
endmodule
`default_nettype wire

/* rtl/cdph_back.sv */
// Back end: sequencer that runs one request at a time against the coefficient
// and histogram RAMs, the shared multiplier and divider. Uses cdph_pkg,
// cdph_ram, cdph_div.
`timescale 1ns / 1ps
`default_nettype none
module cdph_back #(
  parameter int NUM_DETECTORS = cdph_pkg::DEF_NUM_DETECTORS,
  parameter int NUM_BINS      = cdph_pkg::DEF_NUM_BINS,
  parameter int COUNT_WIDTH   = cdph_pkg::DEF_COUNT_WIDTH
) (
  input  logic           clk,
  input  logic           rst,
  input  logic [31:0]    energy_threshold,
  input  logic           cmd_valid,
  input  cdph_pkg::cmd_t cmd,
  output logic           cmd_pop,
  output logic           init_busy,
  output logic           m_axis_tvalid,
  input  logic           m_axis_tready,
  output logic [87:0]    m_axis_tdata,
  output logic [2:0]     m_axis_tuser
);
  localparam int DET_W      = (NUM_DETECTORS > 1) ? $clog2(NUM_DETECTORS) : 1;
  localparam int HIST_SLOTS = NUM_BINS + 2;
  localparam int SLOT_W     = $clog2(HIST_SLOTS);
  localparam int HA_W       = DET_W + SLOT_W;
  localparam int CA_W       = DET_W + cdph_pkg::COEF_SEL_W;
  localparam int TW         = SLOT_W + 2;
  localparam logic signed [49:0] FS_HI = 50'(cdph_pkg::END_LIMIT);
  localparam logic signed [49:0] FS_LO = -FS_HI;
  localparam logic signed [64:0] NS_HI = 65'(cdph_pkg::END_LIMIT);
  localparam logic signed [64:0] NS_LO = -NS_HI;

  typedef enum logic [23:0] {
    S_INIT = 24'h000001, S_IDLE = 24'h000002, S_LOAD = 24'h000004,
    S_RD   = 24'h000008, S_RDD  = 24'h000010, S_CLR  = 24'h000020,
    S_COEF = 24'h000040, S_ESET = 24'h000080, S_EDIV = 24'h000100,
    S_EADD = 24'h000200, S_ETHR = 24'h000400, S_MF   = 24'h000800,
    S_MNB  = 24'h001000, S_MLO  = 24'h002000, S_MHI  = 24'h004000,
    S_ENDS = 24'h008000, S_NC   = 24'h010000, S_PSET = 24'h020000,
    S_PDIV = 24'h040000, S_BIN1 = 24'h080000, S_BIN2 = 24'h100000,
    S_HRD  = 24'h200000, S_HUPD = 24'h400000, S_OUT  = 24'h800000
  } state_t;

  state_t         state;
  cdph_pkg::cmd_t cur;
  logic [HA_W-1:0] sweep;
  logic [2:0]      cidx;
  logic [31:0]     coef [5];

  logic signed [31:0] qe, ec;
  logic signed [47:0] fprod, nb, fc, nc;
  logic signed [57:0] plo, phi;
  logic signed [63:0] nfull;
  logic signed [15:0] p, p_bias;
  logic               div_neg;
  logic [TW-1:0]      t;
  logic [SLOT_W-1:0]  slot;

  cdph_pkg::status_t res_status;
  logic [15:0]       res_position;
  logic [7:0]        res_bin;
  logic [31:0]       res_count;
  logic [31:0]       res_energy;

  logic [DET_W-1:0] det_idx;
  logic             out_free;

  // shared multiplier
  logic signed [24:0] mul_a;
  logic signed [32:0] mul_b;
  logic signed [57:0] mul_p;

  // divider
  logic                           div_start, div_done;
  logic [cdph_pkg::DIV_NUM_W-1:0] div_num, div_quot;
  logic [cdph_pkg::DIV_DEN_W-1:0] div_den;
  logic signed [64:0]             qsig;
  logic signed [65:0]             psum;

  // RAM ports
  logic                   h_we;
  logic [HA_W-1:0]        h_waddr, h_raddr;
  logic [COUNT_WIDTH-1:0] h_wdata, h_rdata, cnt_inc;
  logic                   c_we;
  logic [CA_W-1:0]        c_waddr, c_raddr;
  logic [31:0]            c_rdata;

  // datapath terms
  logic [31:0]        g_abs;
  logic signed [48:0] end_sum, end_diff;
  logic [48:0]        sum_abs, diff_abs;
  logic [47:0]        fc_abs, nc_abs;
  logic [16:0]        two_e;
  logic               f_pres, n_pres;
  logic signed [32:0] esum;
  logic signed [49:0] fsum;
  logic signed [80:0] nwide;
  logic signed [64:0] nsum;
  logic signed [19:0] v;
  logic [TW-1:0]      k;

  function automatic logic [31:0] sat32(input logic [COUNT_WIDTH-1:0] c);
    logic [63:0] ext;
    ext = 64'(c);
    return (ext > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : ext[31:0];
  endfunction

  assign det_idx   = DET_W'(cur.detector);
  assign init_busy = state == S_INIT;
  assign out_free  = !m_axis_tvalid || m_axis_tready;
  assign cmd_pop   = (state == S_IDLE) && cmd_valid;

  assign g_abs    = coef[cdph_pkg::CSEL_EGAIN][31] ? (~coef[cdph_pkg::CSEL_EGAIN] + 32'd1)
                                                   : coef[cdph_pkg::CSEL_EGAIN];
  assign end_sum  = 49'(fc) + 49'(nc);
  assign end_diff = 49'(fc) - 49'(nc);
  assign sum_abs  = end_sum[48] ? (~end_sum + 49'd1) : end_sum;
  assign diff_abs = end_diff[48] ? (~end_diff + 49'd1) : end_diff;
  assign fc_abs   = fc[47] ? (~fc + 48'd1) : fc;
  assign nc_abs   = nc[47] ? (~nc + 48'd1) : nc;
  assign two_e    = {cur.energy_raw, 1'b0};
  assign f_pres   = cur.far_raw != 16'd0;
  assign n_pres   = cur.near_raw != 16'd0;

  assign qsig  = div_neg ? -$signed({1'b0, div_quot}) : $signed({1'b0, div_quot});
  assign psum  = 66'(qsig) + 66'(p_bias);
  assign esum  = 33'(qe) + 33'($signed(coef[cdph_pkg::CSEL_EOFF]) >>> 8);
  assign fsum  = 50'(fprod) + 50'($signed(coef[cdph_pkg::CSEL_OFF]));
  assign nwide = (81'(phi) <<< 24) + 81'(plo);
  assign nsum  = 65'(nfull) + 65'($signed(coef[cdph_pkg::CSEL_OFF]));
  assign v     = (20'(p) <<< 2) + 20'(p) + 20'sd98304;
  assign k     = mul_p[TW+16:17];
  assign cnt_inc = (h_rdata == '1) ? h_rdata : h_rdata + COUNT_WIDTH'(1);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_MF: begin
        mul_a = 25'(cur.far_raw);
        mul_b = 33'($signed(coef[cdph_pkg::CSEL_GAIN]));
      end
      S_MNB: begin
        mul_a = 25'(cur.near_raw);
        mul_b = 33'($signed(coef[cdph_pkg::CSEL_BAL]));
      end
      S_MLO: begin
        mul_a = $signed({1'b0, nb[23:0]});
        mul_b = 33'($signed(coef[cdph_pkg::CSEL_GAIN]));
      end
      S_MHI: begin
        mul_a = 25'($signed(nb[47:24]));
        mul_b = 33'($signed(coef[cdph_pkg::CSEL_GAIN]));
      end
      S_BIN1: begin
        mul_a = 25'(v);
        mul_b = 33'(NUM_BINS);
      end
      S_BIN2: begin
        mul_a = 25'(t);
        mul_b = 33'(cdph_pkg::RECIP3);
      end
      default: ;
    endcase
  end
  assign mul_p = mul_a * mul_b;

  always_comb begin
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    case (state)
      S_ESET: begin
        div_start = coef[cdph_pkg::CSEL_EGAIN] != 32'd0;
        div_num   = 64'(cur.energy_raw) << 24;
        div_den   = 49'(g_abs);
      end
      S_PSET: begin
        if (f_pres && n_pres) begin
          div_start = end_sum != 49'sd0;
          div_num   = 64'(diff_abs) << 14;
          div_den   = sum_abs;
        end else if (n_pres) begin
          div_start = 1'b1;
          div_num   = 64'(nc_abs);
          div_den   = 49'(two_e);
        end else if (f_pres) begin
          div_start = 1'b1;
          div_num   = 64'(fc_abs);
          div_den   = 49'(two_e);
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    h_we    = 1'b0;
    h_waddr = {det_idx, slot};
    h_wdata = '0;
    h_raddr = {det_idx, slot};
    c_we    = state == S_LOAD;
    c_waddr = {det_idx, cur.coef_select};
    c_raddr = {det_idx, cidx};
    case (state)
      S_INIT: begin
        h_we    = 1'b1;
        h_waddr = sweep;
      end
      S_CLR: begin
        h_we    = 1'b1;
        h_waddr = {det_idx, sweep[SLOT_W-1:0]};
      end
      S_RD: h_raddr = {det_idx, SLOT_W'(cur.bin_index)};
      S_HUPD: begin
        h_we    = 1'b1;
        h_wdata = cnt_inc;
      end
      default: ;
    endcase
  end

  cdph_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(2 ** HA_W)) u_hist (
    .clk(clk), .we(h_we), .waddr(h_waddr), .wdata(h_wdata),
    .raddr(h_raddr), .rdata(h_rdata)
  );

  cdph_ram #(.WIDTH(32), .DEPTH(2 ** CA_W)) u_coef (
    .clk(clk), .we(c_we), .waddr(c_waddr), .wdata(cur.coef_value),
    .raddr(c_raddr), .rdata(c_rdata)
  );

  cdph_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(div_num), .den(div_den),
    .done(div_done), .quot(div_quot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_INIT;
      sweep         <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready && state != S_OUT) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        S_INIT: begin
          sweep <= sweep + HA_W'(1);
          if (sweep == '1) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (cmd_valid) begin
            cur          <= cmd;
            res_position <= '0;
            res_bin      <= (cmd.opcode == cdph_pkg::OP_READ) ? cmd.bin_index : 8'd0;
            res_count    <= '0;
            res_energy   <= '0;
            cidx         <= '0;
            sweep        <= '0;
            case (cmd.opcode)
              cdph_pkg::OP_HIT: begin
                res_status <= cdph_pkg::ST_NO_EN;
                state      <= (cmd.det_ok && cmd.energy_raw != 16'd0) ? S_COEF : S_OUT;
              end
              cdph_pkg::OP_LOAD: begin
                res_status <= cdph_pkg::ST_STORED;
                state      <= (cmd.det_ok && cmd.sel_ok) ? S_LOAD : S_OUT;
              end
              cdph_pkg::OP_READ: begin
                res_status <= cdph_pkg::ST_READ;
                state      <= (cmd.det_ok && cmd.bin_ok) ? S_RD : S_OUT;
              end
              cdph_pkg::OP_CLEAR: begin
                res_status <= cdph_pkg::ST_CLEARED;
                state      <= cmd.det_ok ? S_CLR : S_OUT;
              end
              default: state <= S_OUT;
            endcase
          end
        end
        S_LOAD: state <= S_OUT;
        S_RD: state <= S_RDD;
        S_RDD: begin
          res_count <= sat32(h_rdata);
          state     <= S_OUT;
        end
        S_CLR: begin
          sweep <= sweep + HA_W'(1);
          if (sweep[SLOT_W-1:0] == SLOT_W'(HIST_SLOTS - 1)) begin
            state <= S_OUT;
          end
        end
        S_COEF: begin
          // read address runs one ahead of the captured word
          cidx <= cidx + 3'd1;
          if (cidx != 3'd0) begin
            coef[cidx - 3'd1] <= c_rdata;
          end
          if (cidx == 3'd5) begin
            state <= S_ESET;
          end
        end
        S_ESET: begin
          div_neg <= coef[cdph_pkg::CSEL_EGAIN][31];
          if (coef[cdph_pkg::CSEL_EGAIN] == 32'd0) begin
            qe    <= 32'sh7FFF_FFFF;
            state <= S_EADD;
          end else begin
            state <= S_EDIV;
          end
        end
        S_EDIV: begin
          if (div_done) begin
            if (qsig > 65'sd2147483647) begin
              qe <= 32'sh7FFF_FFFF;
            end else if (qsig < -65'sd2147483648) begin
              qe <= 32'sh8000_0000;
            end else begin
              qe <= qsig[31:0];
            end
            state <= S_EADD;
          end
        end
        S_EADD: begin
          if (esum > 33'sd2147483647) begin
            ec <= 32'sh7FFF_FFFF;
          end else if (esum < -33'sd2147483648) begin
            ec <= 32'sh8000_0000;
          end else begin
            ec <= esum[31:0];
          end
          state <= S_ETHR;
        end
        S_ETHR: begin
          res_energy <= ec;
          if (ec < $signed(energy_threshold)) begin
            res_status <= cdph_pkg::ST_BELOW;
            state      <= S_OUT;
          end else begin
            state <= S_MF;
          end
        end
        S_MF: begin
          fprod <= mul_p[47:0];
          state <= S_MNB;
        end
        S_MNB: begin
          nb    <= mul_p[47:0];
          state <= S_MLO;
        end
        S_MLO: begin
          plo   <= mul_p;
          state <= S_MHI;
        end
        S_MHI: begin
          phi   <= mul_p;
          state <= S_ENDS;
        end
        S_ENDS: begin
          if (fsum > FS_HI) begin
            fc <= cdph_pkg::END_LIMIT;
          end else if (fsum < FS_LO) begin
            fc <= -cdph_pkg::END_LIMIT;
          end else begin
            fc <= fsum[47:0];
          end
          nfull <= nwide[79:16];
          state <= S_NC;
        end
        S_NC: begin
          if (nsum > NS_HI) begin
            nc <= cdph_pkg::END_LIMIT;
          end else if (nsum < NS_LO) begin
            nc <= -cdph_pkg::END_LIMIT;
          end else begin
            nc <= nsum[47:0];
          end
          state <= S_PSET;
        end
        S_PSET: begin
          if (f_pres && n_pres) begin
            div_neg <= end_diff[48] ^ end_sum[48];
            p_bias  <= 16'sd0;
            if (end_sum == 49'sd0) begin
              res_status <= cdph_pkg::ST_NO_POS;
              state      <= S_OUT;
            end else begin
              state <= S_PDIV;
            end
          end else if (n_pres) begin
            // 1 - n/(2e): negate the quotient, then add one
            div_neg <= ~nc[47];
            p_bias  <= cdph_pkg::ONE_Q14;
            state   <= S_PDIV;
          end else if (f_pres) begin
            div_neg <= fc[47];
            p_bias  <= -cdph_pkg::ONE_Q14;
            state   <= S_PDIV;
          end else begin
            res_status <= cdph_pkg::ST_NO_POS;
            state      <= S_OUT;
          end
        end
        S_PDIV: begin
          if (div_done) begin
            if (psum > 66'sd32767) begin
              p <= 16'sh7FFF;
            end else if (psum < -66'sd32768) begin
              p <= 16'sh8000;
            end else begin
              p <= psum[15:0];
            end
            state <= S_BIN1;
          end
        end
        S_BIN1: begin
          res_position <= p;
          if (v[19]) begin
            slot  <= '0;
            state <= S_HRD;
          end else begin
            t     <= mul_p[TW+15:16];
            state <= S_BIN2;
          end
        end
        S_BIN2: begin
          if (k >= TW'(NUM_BINS)) begin
            slot <= SLOT_W'(NUM_BINS + 1);
          end else begin
            slot <= SLOT_W'(k) + SLOT_W'(1);
          end
          state <= S_HRD;
        end
        S_HRD: state <= S_HUPD;
        S_HUPD: begin
          res_status <= cdph_pkg::ST_FILLED;
          res_bin    <= 8'(slot);
          res_count  <= sat32(cnt_inc);
          state      <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tuser  <= res_status;
            m_axis_tdata  <= {res_energy, res_count, res_bin, res_position};
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire
